/* src/fagr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fagr_pkg: shared types for the fraction arithmetic block
// Operation codes, state encodings and the word passed from front to back.
// ----------------------------------------------------------------------------
package fagr_pkg;

  localparam int MAG_W = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Raw fraction in sign-magnitude form, before reduction
  typedef struct packed {
    logic             num_neg;
    logic [MAG_W-1:0] num_mag;
    logic             den_neg;
    logic [MAG_W-1:0] den_mag;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_M0,
    F_M1,
    F_M2,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EVEN,
    B_LOOP,
    B_DIVN,
    B_DIVD,
    B_DONE
  } back_state_t;

endpackage

/* src/fagr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fagr_front: operand capture and cross-multiplication
// Takes one request, forms the raw numerator and denominator with one shared
// multiplier, and hands the raw fraction to the queue.
// ----------------------------------------------------------------------------
module fagr_front #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            req_type,
  input  logic signed [31:0]    a_num,
  input  logic signed [31:0]    a_den,
  input  logic signed [31:0]    b_num,
  input  logic signed [31:0]    b_den,
  output logic                  q_push,
  input  logic                  q_full,
  output fagr_pkg::entry_t      q_word
);

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;

  fagr_pkg::front_state_t state, state_next;

  logic          an_neg, ad_neg, bn_neg, bd_neg;
  logic [OW-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic          is_sum;
  logic          p0_neg, p1_neg;
  logic [63:0]   p0_mag, p1_mag;
  fagr_pkg::entry_t word;

  logic          ma_neg, mb_neg;
  logic [OW-1:0] ma_mag, mb_mag;
  logic [PW-1:0] prod;
  logic [63:0]   prod_mag;
  logic          prod_neg;

  logic [OW-1:0] v_an, v_ad, v_bn, v_bd;
  logic [63:0]   sum_mag;
  logic          sum_neg;

  function automatic logic [OPERAND_WIDTH-1:0] take_mag(input logic [OPERAND_WIDTH-1:0] v);
    take_mag = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign v_an = a_num[OW-1:0];
  assign v_ad = a_den[OW-1:0];
  assign v_bn = b_num[OW-1:0];
  assign v_bd = b_den[OW-1:0];

  assign full   = (state != fagr_pkg::F_IDLE);
  assign q_push = (state == fagr_pkg::F_PUSH) && !q_full;
  assign q_word = word;

  // Select multiplier operands by step
  always_comb begin
    ma_neg = an_neg; ma_mag = an_mag;
    mb_neg = bd_neg; mb_mag = bd_mag;
    case (state)
      fagr_pkg::F_M0: begin
        if (!is_sum) begin
          mb_neg = bn_neg; mb_mag = bn_mag;
        end
      end
      fagr_pkg::F_M1: begin
        ma_neg = ad_neg; ma_mag = ad_mag;
        mb_neg = bn_neg; mb_mag = bn_mag;
      end
      fagr_pkg::F_M2: begin
        ma_neg = ad_neg; ma_mag = ad_mag;
      end
      default: begin
      end
    endcase
  end

  assign prod     = PW'(ma_mag) * PW'(mb_mag);
  assign prod_mag = 64'(prod);
  assign prod_neg = (ma_neg != mb_neg) && (prod_mag != 64'd0);

  // Signed add of the two cross products
  always_comb begin
    if (p0_neg == p1_neg) begin
      sum_mag = p0_mag + p1_mag;
      sum_neg = p0_neg;
    end else if (p0_mag >= p1_mag) begin
      sum_mag = p0_mag - p1_mag;
      sum_neg = p0_neg;
    end else begin
      sum_mag = p1_mag - p0_mag;
      sum_neg = p1_neg;
    end
    if (sum_mag == 64'd0) sum_neg = 1'b0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fagr_pkg::F_IDLE: if (push) state_next = fagr_pkg::F_M0;
      fagr_pkg::F_M0:   state_next = is_sum ? fagr_pkg::F_M1 : fagr_pkg::F_M2;
      fagr_pkg::F_M1:   state_next = fagr_pkg::F_M2;
      fagr_pkg::F_M2:   state_next = is_sum ? fagr_pkg::F_SUM : fagr_pkg::F_PUSH;
      fagr_pkg::F_SUM:  state_next = fagr_pkg::F_PUSH;
      fagr_pkg::F_PUSH: if (!q_full) state_next = fagr_pkg::F_IDLE;
      default:          state_next = fagr_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fagr_pkg::F_IDLE;
    else     state <= state_next;
  end

  // Capture operands, swap for divide, flip sign for subtract; run products
  always_ff @(posedge clk) begin
    case (state)
      fagr_pkg::F_IDLE: begin
        an_neg <= v_an[OW-1]; an_mag <= take_mag(v_an);
        ad_neg <= v_ad[OW-1]; ad_mag <= take_mag(v_ad);
        is_sum <= (req_type == fagr_pkg::OP_ADD) || (req_type == fagr_pkg::OP_SUB);
        if (req_type == fagr_pkg::OP_DIV) begin
          bn_neg <= v_bd[OW-1]; bn_mag <= take_mag(v_bd);
          bd_neg <= v_bn[OW-1]; bd_mag <= take_mag(v_bn);
        end else begin
          bn_neg <= v_bn[OW-1]; bn_mag <= take_mag(v_bn);
          bd_neg <= v_bd[OW-1] ^ (req_type == fagr_pkg::OP_SUB);
          bd_mag <= take_mag(v_bd);
        end
      end
      fagr_pkg::F_M0: begin
        p0_neg <= prod_neg; p0_mag <= prod_mag;
        word.num_neg <= prod_neg; word.num_mag <= prod_mag;
      end
      fagr_pkg::F_M1: begin
        p1_neg <= prod_neg; p1_mag <= prod_mag;
      end
      fagr_pkg::F_M2: begin
        word.den_neg <= prod_neg; word.den_mag <= prod_mag;
      end
      fagr_pkg::F_SUM: begin
        word.num_neg <= sum_neg; word.num_mag <= sum_mag;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/fagr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fagr_queue: two-word queue between front and back
// Decouples the multiply stage from the reduction stage.
// ----------------------------------------------------------------------------
module fagr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  fagr_pkg::entry_t wr_word,
  output logic             q_full,
  input  logic             rd,
  output logic             q_empty,
  output fagr_pkg::entry_t rd_word
);

  fagr_pkg::entry_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_word = mem[rp];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_word;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* src/fagr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fagr_back: GCD reduction and result register
// Binary GCD one step a cycle, then two restoring divisions by the GCD on one
// shared divider, then normalise sign and hold the word for the consumer.
// ----------------------------------------------------------------------------
module fagr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  fagr_pkg::entry_t    rd_word,
  output logic                rd,
  output logic                empty,
  input  logic                pop,
  output logic signed [63:0]  res_num,
  output logic [62:0]         res_den,
  output logic                status
);

  localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};

  fagr_pkg::back_state_t state, state_next;

  fagr_pkg::entry_t cur;
  logic [63:0] x, y, g, q, nm;
  logic [63:0] rem;
  logic [5:0]  k, cnt;
  logic [63:0] s_num;
  logic [62:0] s_den;
  logic        s_stat;
  logic        ovalid;

  logic [64:0] trial;
  logic        fits;
  logic        res_neg;
  logic [63:0] nm_sat, raw_sat;

  assign trial   = {rem, q[63]};
  assign fits    = trial >= {1'b0, g};
  assign res_neg = (cur.num_neg != cur.den_neg) && (nm != 64'd0);
  assign nm_sat  = (nm > SAT_MAX) ? SAT_MAX : nm;
  assign raw_sat = (rd_word.num_mag > SAT_MAX) ? SAT_MAX : rd_word.num_mag;

  assign rd      = (state == fagr_pkg::B_IDLE) && !q_empty;
  assign empty   = !ovalid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fagr_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (rd_word.den_mag == 64'd0 || rd_word.num_mag == 64'd0)
            state_next = fagr_pkg::B_DONE;
          else
            state_next = fagr_pkg::B_EVEN;
        end
      end
      fagr_pkg::B_EVEN: if (x[0] || y[0]) state_next = fagr_pkg::B_LOOP;
      fagr_pkg::B_LOOP: if (x == 64'd0) state_next = fagr_pkg::B_DIVN;
      fagr_pkg::B_DIVN: if (cnt == 6'd63) state_next = fagr_pkg::B_DIVD;
      fagr_pkg::B_DIVD: if (cnt == 6'd63) state_next = fagr_pkg::B_DONE;
      fagr_pkg::B_DONE: if (!ovalid || pop) state_next = fagr_pkg::B_IDLE;
      default:          state_next = fagr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fagr_pkg::B_IDLE;
    else     state <= state_next;
  end

  // Datapath: load, strip common twos, subtract-and-halve, divide
  always_ff @(posedge clk) begin
    case (state)
      fagr_pkg::B_IDLE: begin
        cur <= rd_word;
        x   <= rd_word.num_mag;
        y   <= rd_word.den_mag;
        k   <= 6'd0;
        cnt <= 6'd0;
        if (rd_word.den_mag == 64'd0) begin
          s_num  <= rd_word.num_neg ? (~raw_sat + 64'd1) : raw_sat;
          s_den  <= 63'd0;
          s_stat <= 1'b1;
        end else begin
          s_num  <= 64'd0;
          s_den  <= 63'd1;
          s_stat <= 1'b0;
        end
      end
      fagr_pkg::B_EVEN: begin
        if (!x[0] && !y[0]) begin
          x <= x >> 1; y <= y >> 1; k <= k + 6'd1;
        end
      end
      fagr_pkg::B_LOOP: begin
        if (x == 64'd0) begin
          g   <= y << k;
          q   <= cur.num_mag;
          rem <= 64'd0;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      fagr_pkg::B_DIVN, fagr_pkg::B_DIVD: begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63 && state == fagr_pkg::B_DIVN) begin
          nm  <= {q[62:0], fits};
          q   <= cur.den_mag;
          rem <= 64'd0;
        end else begin
          rem <= fits ? 64'(trial - {1'b0, g}) : trial[63:0];
          q   <= {q[62:0], fits};
          // Sign-normalised result after the second division
          if (cnt == 6'd63) begin
            s_den  <= {q[61:0], fits};
            s_stat <= 1'b0;
            s_num  <= res_neg ? (~nm_sat + 64'd1) : nm_sat;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hand the finished word to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == fagr_pkg::B_DONE && (!ovalid || pop)) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fagr_pkg::B_DONE && (!ovalid || pop)) begin
      res_num <= s_num;
      res_den <= s_den;
      status  <= s_stat;
    end
  end

endmodule

/* src/fraction_arith_gcd_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arith_gcd_reduce: rational add/sub/mul/div with GCD reduction
// Combines two signed fractions and returns the reduced fraction.
// ----------------------------------------------------------------------------
// In the front, one request uses one shared multiplier: two products for
// multiply and divide, three plus a signed add for add and subtract. The back
// then strips common twos, runs binary GCD steps and performs two 64-bit
// restoring divisions on one shared divider; a zero numerator or denominator
// skips the reduction. A two-word queue lets the front take the next request
// while the back reduces. A zero raw denominator gives status 1, res_den 0
// and the raw numerator; a zero numerator gives 0/1.
// ----------------------------------------------------------------------------
module fraction_arith_gcd_reduce #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] res_num,
  output logic [62:0]        res_den,
  output logic               status
);

  logic             q_push, q_full, q_empty, q_rd;
  fagr_pkg::entry_t q_in, q_out;

  fagr_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst, .push, .full, .req_type, .a_num, .a_den, .b_num, .b_den,
    .q_push, .q_full, .q_word(q_in)
  );

  fagr_queue u_queue (
    .clk, .rst, .wr(q_push), .wr_word(q_in), .q_full,
    .rd(q_rd), .q_empty, .rd_word(q_out)
  );

  fagr_back u_back (
    .clk, .rst, .q_empty, .rd_word(q_out), .rd(q_rd),
    .empty, .pop, .res_num, .res_den, .status
  );

  // A valid word without the status flag never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !status) |-> (res_den != 63'd0))
    else $error("valid result with zero denominator");

  // A flagged word carries a zero denominator
  a_flag_den: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (res_den == 63'd0))
    else $error("flagged result with nonzero denominator");

  // Zero reduces to 0/1
  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && !status && res_num == 64'sd0) |-> (res_den == 63'd1))
    else $error("zero result not in 0/1 form");

endmodule

/* tb/fraction_arith_gcd_reduce_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arith_gcd_reduce_chk: result checker for the fraction block
// Watches accepted request and result words, computes the reduced fraction
// for each request and compares every result word field by field.
// ----------------------------------------------------------------------------
module fraction_arith_gcd_reduce_chk #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [63:0] res_num,
  input  logic [62:0]        res_den,
  input  logic               status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        st;
  } frac_res_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  frac_res_t reduced_q[$];

  function automatic smag_t operand(logic [31:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    smag_t r;
    mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    v = {32'd0, raw} & mask;
    r.neg = v[OPERAND_WIDTH-1];
    r.mag = r.neg ? ((~v + 64'd1) & mask) : v;
    return r;
  endfunction

  function automatic smag_t mul_sm(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (x.neg != y.neg) && r.mag != 0;
    return r;
  endfunction

  function automatic smag_t add_sm(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] to_bits(logic neg, logic [63:0] mag);
    logic [63:0] m;
    m = (mag > 64'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : mag;
    return neg ? (~m + 64'd1) : m;
  endfunction

  function automatic frac_res_t reduce_fraction(fagr_pkg::op_t op, logic [31:0] an_r,
      logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r);
    smag_t an, ad, bn, bd, tmp, num, den;
    logic [63:0] x, y, t, nm, dm;
    frac_res_t r;
    an = operand(an_r);
    ad = operand(ad_r);
    bn = operand(bn_r);
    bd = operand(bd_r);
    if (op == fagr_pkg::OP_DIV) begin
      tmp = bn;
      bn = bd;
      bd = tmp;
    end
    if (op == fagr_pkg::OP_SUB) bd.neg = !bd.neg;
    if (op == fagr_pkg::OP_ADD || op == fagr_pkg::OP_SUB)
      num = add_sm(mul_sm(an, bd), mul_sm(ad, bn));
    else num = mul_sm(an, bn);
    den = mul_sm(ad, bd);
    if (den.mag == 0) begin
      r.num = to_bits(num.neg, num.mag);
      r.den = '0;
      r.st = 1'b1;
      return r;
    end
    x = num.mag;
    y = den.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = num.mag / x;
    dm = den.mag / x;
    r.num = to_bits((num.neg != den.neg) && nm != 0, nm);
    r.den = dm[62:0];
    r.st = 1'b0;
    return r;
  endfunction

  assign pending = reduced_q.size();

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (push && !full)
        reduced_q.push_back(reduce_fraction(fagr_pkg::op_t'(req_type), a_num, a_den,
                                            b_num, b_den));
      if (pop && !empty) begin
        if (reduced_q.size() == 0) begin
          $error("result word with nothing expected: %0d/%0d st %0d",
                 res_num, res_den, status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = reduced_q.pop_front();
          if (res_num !== exp_r.num || res_den !== exp_r.den || status !== exp_r.st)
            fail_count <= fail_count + 1;
          if (res_num !== exp_r.num)
            $error("res_num expected %0d actual %0d", $signed(exp_r.num), res_num);
          if (res_den !== exp_r.den)
            $error("res_den expected %0d actual %0d", exp_r.den, res_den);
          if (status !== exp_r.st)
            $error("status expected %0d actual %0d", exp_r.st, status);
        end
      end
    end
  end

endmodule

/* tb/fraction_arith_gcd_reduce_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arith_gcd_reduce_tb: stimulus and verdict for the fraction block
// Drives directed corner requests, then bursty random requests against a
// randomly stalling result side; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module fraction_arith_gcd_reduce_tb;

  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         req_type = fagr_pkg::OP_ADD;
  logic signed [31:0] a_num = '0;
  logic signed [31:0] a_den = 32'sd1;
  logic signed [31:0] b_num = '0;
  logic signed [31:0] b_den = 32'sd1;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [63:0] res_num;
  logic [62:0]        res_den;
  logic               status;
  int                 fail_count;
  int                 pending;
  logic               hold_results = 1'b0;
  logic               random_phase = 1'b0;
  int                 idle_cycles = 0;

  always #5 clk = ~clk;

  fraction_arith_gcd_reduce u_top (.*);
  fraction_arith_gcd_reduce_chk u_chk (.*);

  // Pick an operand value: corners, small values, or full random bits
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3, 4: return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(fagr_pkg::op_t op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    push     <= 1'b1;
    req_type <= op;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
  endtask

  // Receiver: random stall pattern, plus a hold-off when asked
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !hold_results && ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Long receiver hold-off counted in its own process, while the sender runs
  initial begin
    wait (random_phase);
    repeat (3000) @(posedge clk);
    hold_results = 1'b1;
    repeat (4000) @(posedge clk);
    hold_results = 1'b0;
  end

  initial begin
    int burst;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed corners: every operation, extremes, zero denominators
    for (int op = 0; op < 4; op++) begin
      send_word(fagr_pkg::op_t'(op), 32'd1, 32'd2, 32'd1, 32'd3);
      send_word(fagr_pkg::op_t'(op), 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0001);
      send_word(fagr_pkg::op_t'(op), 32'd0, 32'd5, 32'd7, 32'd0);
      send_word(fagr_pkg::op_t'(op), -32'sd6, 32'd4, 32'd0, -32'sd9);
      send_word(fagr_pkg::op_t'(op), 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                32'h8000_0000);
    end
    send_word(fagr_pkg::OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
    send_word(fagr_pkg::OP_DIV, 32'd5, 32'd8, 32'd0, 32'd3);
    push <= 1'b0;
    // Pause until the block drains
    while (pending != 0) @(posedge clk);
    random_phase = 1'b1;
    // Random bursts with gaps
    for (int i = 0; i < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && i < RANDOM_ITEMS; k++, i++)
        send_word(fagr_pkg::op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/fagr_pkg.sv
src/fagr_front.sv
src/fagr_queue.sv
src/fagr_back.sv
src/fraction_arith_gcd_reduce.sv
tb/fraction_arith_gcd_reduce_chk.sv
tb/fraction_arith_gcd_reduce_tb.sv
